FILE: rtl/mmm_pkg.sv
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types, constants and modular helpers for the masked multiplier.
// ----------------------------------------------------------------------------
package mmm_pkg;

	localparam int NUM_SHARES = 3;
	localparam bit USE_THIRD  = (NUM_SHARES >= 3);

	localparam int SHARE_W = 16;
	localparam int MOD_W   = 17;
	localparam int PROD_W  = 32;
	localparam int MU_W    = 32;

	localparam logic [MOD_W-1:0] MOD_RESET = 17'd8192;
	localparam logic [MOD_W-1:0] MOD_MAX   = 17'd65536;
	// floor((2^32 - 1) / 8192)
	localparam logic [MU_W-1:0]  MU_RESET  = 32'h0007_FFFF;

	// Indices of the reduction lanes.
	localparam int L_D0  = 0;
	localparam int L_D1  = 1;
	localparam int L_D2  = 2;
	localparam int L_R01 = 3;
	localparam int L_R02 = 4;
	localparam int L_R12 = 5;
	localparam int L_P01 = 6;
	localparam int L_P10 = 7;
	localparam int L_P02 = 8;
	localparam int L_P20 = 9;
	localparam int L_P12 = 10;
	localparam int L_P21 = 11;
	localparam int LANES = 12;

	typedef struct packed {
		logic [SHARE_W-1:0] d0;
		logic [SHARE_W-1:0] d1;
		logic [SHARE_W-1:0] d2;
		logic [SHARE_W-1:0] r01;
		logic [SHARE_W-1:0] r02;
		logic [SHARE_W-1:0] r12;
		logic [SHARE_W-1:0] p01;
		logic [SHARE_W-1:0] p10;
		logic [SHARE_W-1:0] p02;
		logic [SHARE_W-1:0] p20;
		logic [SHARE_W-1:0] p12;
		logic [SHARE_W-1:0] p21;
	} resid_t;

	// Both operands lie below q.
	function automatic logic [SHARE_W-1:0] mod_add(input logic [SHARE_W-1:0] x,
			input logic [SHARE_W-1:0] y, input logic [MOD_W-1:0] q);
		logic [MOD_W-1:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= q) begin
			s = s - q;
		end
		return s[SHARE_W-1:0];
	endfunction

	function automatic logic [SHARE_W-1:0] mod_sub(input logic [SHARE_W-1:0] x,
			input logic [SHARE_W-1:0] y, input logic [MOD_W-1:0] q);
		logic [MOD_W-1:0] s;
		if (x >= y) begin
			s = {1'b0, x} - {1'b0, y};
		end else begin
			s = {1'b0, x} + q - {1'b0, y};
		end
		return s[SHARE_W-1:0];
	endfunction

endpackage

FILE: rtl/mmm_mu_div.sv
// ----------------------------------------------------------------------------
// mmm_mu_div
// Modulus register and bit-serial divider for the Barrett constant.
// ----------------------------------------------------------------------------
module mmm_mu_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       modulus_we,
	input  logic [mmm_pkg::MOD_W-1:0]  modulus_wdata,
	output logic [mmm_pkg::MOD_W-1:0]  q,
	output logic [mmm_pkg::MU_W-1:0]   mu,
	output logic                       div_busy
);
	import mmm_pkg::*;

	logic [MOD_W-1:0] q_q;
	logic [MU_W-1:0]  mu_q;
	logic [MOD_W-1:0] rem_q;
	logic [4:0]       cnt_q;
	logic             active_q;
	logic [MOD_W-1:0] q_eff;
	logic [MOD_W:0]   rem_sh;
	logic             take;

	always_comb begin
		if (modulus_wdata == '0) begin
			q_eff = MOD_W'(1);
		end else if (modulus_wdata > MOD_MAX) begin
			q_eff = MOD_MAX;
		end else begin
			q_eff = modulus_wdata;
		end
	end

	// The dividend is all ones, so a one is shifted in at every step.
	assign rem_sh = {rem_q, 1'b1};
	assign take   = (rem_sh >= {1'b0, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q      <= MOD_RESET;
			mu_q     <= MU_RESET;
			rem_q    <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
		end else if (modulus_we) begin
			q_q      <= q_eff;
			mu_q     <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			if (take) begin
				rem_q <= MOD_W'(rem_sh - {1'b0, q_q});
			end else begin
				rem_q <= rem_sh[MOD_W-1:0];
			end
			mu_q  <= {mu_q[MU_W-2:0], take};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				active_q <= 1'b0;
			end
		end
	end

	assign q        = q_q;
	assign mu       = mu_q;
	assign div_busy = active_q;

endmodule

FILE: rtl/mmm_barrett.sv
// ----------------------------------------------------------------------------
// mmm_barrett
// Three-stage Barrett reduction of a 32-bit value by the modulus.
// ----------------------------------------------------------------------------
module mmm_barrett (
	input  logic                        clk,
	input  logic [mmm_pkg::PROD_W-1:0]  x,
	input  logic [mmm_pkg::MOD_W-1:0]   q,
	input  logic [mmm_pkg::MU_W-1:0]    mu,
	output logic [mmm_pkg::SHARE_W-1:0] res
);
	import mmm_pkg::*;

	logic [PROD_W+MU_W-1:0] m_s1;
	logic [17:0]            x_s1;
	logic [17:0]            x_s2;
	logic [17:0]            p_s2;
	logic [SHARE_W-1:0]     res_s3;
	logic [MOD_W+17:0]      p_full;
	logic [17:0]            r;

	// The quotient estimate is the product shifted down by 32 bits. Only the
	// low 18 bits of the estimate times q matter: the remainder is below 2q.
	assign p_full = m_s1[MU_W +: 18] * q;
	assign r      = x_s2 - p_s2;

	always_ff @(posedge clk) begin
		m_s1 <= x * mu;
		x_s1 <= x[17:0];
		x_s2 <= x_s1;
		p_s2 <= p_full[17:0];
		if (r >= {1'b0, q}) begin
			res_s3 <= SHARE_W'(r - {1'b0, q});
		end else begin
			res_s3 <= r[SHARE_W-1:0];
		end
	end

	assign res = res_s3;

endmodule

FILE: rtl/mmm_combine.sv
// ----------------------------------------------------------------------------
// mmm_combine
// Four-stage modular adder tree that forms the output shares.
// ----------------------------------------------------------------------------
module mmm_combine (
	input  logic                        clk,
	input  mmm_pkg::resid_t             rd,
	input  logic [mmm_pkg::MOD_W-1:0]   q,
	output logic [mmm_pkg::SHARE_W-1:0] c0,
	output logic [mmm_pkg::SHARE_W-1:0] c1,
	output logic [mmm_pkg::SHARE_W-1:0] c2
);
	import mmm_pkg::*;

	logic [SHARE_W-1:0] d0_s1, d1_s1, d2_s1, r01_s1, r02_s1, r12_s1;
	logic [SHARE_W-1:0] u0_s1, u1_s1, u2a_s1, u2b_s1;
	logic [SHARE_W-1:0] c0_s2, v1_s2, w1_s2, v2_s2, w2_s2, r12_s2;
	logic [SHARE_W-1:0] c0_s3, c1_s3, x2_s3, r12_s3;
	logic [SHARE_W-1:0] c0_s4, c1_s4, c2_s4;

	always_ff @(posedge clk) begin
		d0_s1  <= rd.d0;
		d1_s1  <= rd.d1;
		d2_s1  <= rd.d2;
		r01_s1 <= rd.r01;
		r02_s1 <= rd.r02;
		r12_s1 <= rd.r12;
		u0_s1  <= mod_add(rd.r01, rd.r02, q);
		u1_s1  <= mod_add(rd.p01, rd.p10, q);
		u2a_s1 <= mod_add(rd.p02, rd.p20, q);
		u2b_s1 <= mod_add(rd.p12, rd.p21, q);

		c0_s2  <= mod_sub(d0_s1, u0_s1, q);
		v1_s2  <= mod_add(d1_s1, r01_s1, q);
		w1_s2  <= mod_sub(u1_s1, r12_s1, q);
		v2_s2  <= mod_add(d2_s1, r02_s1, q);
		w2_s2  <= mod_add(u2a_s1, u2b_s1, q);
		r12_s2 <= r12_s1;

		c0_s3  <= c0_s2;
		c1_s3  <= mod_add(v1_s2, w1_s2, q);
		x2_s3  <= mod_add(v2_s2, w2_s2, q);
		r12_s3 <= r12_s2;

		c0_s4  <= c0_s3;
		c1_s4  <= c1_s3;
		c2_s4  <= mod_add(x2_s3, r12_s3, q);
	end

	assign c0 = c0_s4;
	assign c1 = c1_s4;
	assign c2 = c2_s4;

endmodule

FILE: rtl/masked_modular_multiply_core.sv
// ----------------------------------------------------------------------------
// masked_modular_multiply_core
// Three-share ISW masked multiplication modulo a programmable q.
// ----------------------------------------------------------------------------
// done rises with the result shares, after the product, reduction and combining stages.
// Throughput: one word per cycle while busy is low, set by the fully pipelined Barrett lanes.
// A modulus write holds busy high while the Barrett constant is rebuilt
// by a one-bit-per-cycle divider.
// Reset clears the valid pipeline and loads the modulus 8192 and its
// constant; the receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module masked_modular_multiply_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        modulus_we,
	input  logic [mmm_pkg::MOD_W-1:0]   modulus_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic [mmm_pkg::SHARE_W-1:0] a_share0,
	input  logic [mmm_pkg::SHARE_W-1:0] a_share1,
	input  logic [mmm_pkg::SHARE_W-1:0] a_share2,
	input  logic [mmm_pkg::SHARE_W-1:0] b_share0,
	input  logic [mmm_pkg::SHARE_W-1:0] b_share1,
	input  logic [mmm_pkg::SHARE_W-1:0] b_share2,
	input  logic [mmm_pkg::SHARE_W-1:0] rand_01,
	input  logic [mmm_pkg::SHARE_W-1:0] rand_02,
	input  logic [mmm_pkg::SHARE_W-1:0] rand_12,
	output logic                        done,
	output logic [mmm_pkg::SHARE_W-1:0] c_share0,
	output logic [mmm_pkg::SHARE_W-1:0] c_share1,
	output logic [mmm_pkg::SHARE_W-1:0] c_share2
);
	import mmm_pkg::*;

	localparam int DEPTH = 8;

	logic [MOD_W-1:0]   q;
	logic [MU_W-1:0]    mu;
	logic               div_busy;
	logic               accept;
	logic [DEPTH-1:0]   valid_q;
	logic [SHARE_W-1:0] a2, b2, r02, r12;
	logic [PROD_W-1:0]  x_s1 [LANES];
	logic [SHARE_W-1:0] red  [LANES];
	resid_t             rd;

	// The user must change the modulus only while the pipeline is empty; the block
	// does not enforce it. q and mu are shared by every lane, not staged with the data.
	mmm_mu_div u_mu_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata),
		.q             (q),
		.mu            (mu),
		.div_busy      (div_busy)
	);

	assign busy   = div_busy;
	assign accept = start && !div_busy;

	// With only two shares in use, every term that touches the third share
	// is forced to zero, which leaves the third output share at zero.
	assign a2  = USE_THIRD ? a_share2 : '0;
	assign b2  = USE_THIRD ? b_share2 : '0;
	assign r02 = USE_THIRD ? rand_02  : '0;
	assign r12 = USE_THIRD ? rand_12  : '0;

	// First stage: all nine partial products, plus the random words widened
	// so that they go through the same reduction lanes.
	always_ff @(posedge clk) begin
		x_s1[L_D0]  <= a_share0 * b_share0;
		x_s1[L_D1]  <= a_share1 * b_share1;
		x_s1[L_D2]  <= a2 * b2;
		x_s1[L_R01] <= PROD_W'(rand_01);
		x_s1[L_R02] <= PROD_W'(r02);
		x_s1[L_R12] <= PROD_W'(r12);
		x_s1[L_P01] <= a_share0 * b_share1;
		x_s1[L_P10] <= a_share1 * b_share0;
		x_s1[L_P02] <= a_share0 * b2;
		x_s1[L_P20] <= a2 * b_share0;
		x_s1[L_P12] <= a_share1 * b2;
		x_s1[L_P21] <= a2 * b_share1;
	end

	// Every value is reduced independently; sums are then formed modulo q.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mmm_barrett u_barrett (
			.clk (clk),
			.x   (x_s1[g]),
			.q   (q),
			.mu  (mu),
			.res (red[g])
		);
	end

	assign rd.d0  = red[L_D0];
	assign rd.d1  = red[L_D1];
	assign rd.d2  = red[L_D2];
	assign rd.r01 = red[L_R01];
	assign rd.r02 = red[L_R02];
	assign rd.r12 = red[L_R12];
	assign rd.p01 = red[L_P01];
	assign rd.p10 = red[L_P10];
	assign rd.p02 = red[L_P02];
	assign rd.p20 = red[L_P20];
	assign rd.p12 = red[L_P12];
	assign rd.p21 = red[L_P21];

	mmm_combine u_combine (
		.clk (clk),
		.rd  (rd),
		.q   (q),
		.c0  (c_share0),
		.c1  (c_share1),
		.c2  (c_share2)
	);

	// The valid bit of each word runs alongside its data: one product stage,
	// three reduction stages and four combining stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[DEPTH-2:0], accept};
		end
	end

	assign done = valid_q[DEPTH-1];

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-share masked modular multiplier. Words
// are driven through the start/busy handshake, a scoreboard predicts the
// product shares modulo the programmed q and checks every done strobe.
// ----------------------------------------------------------------------------

// Scoreboard: predicts the product shares of every accepted word and holds
// them in order until the matching done strobe arrives.
class share_product_board;
	bit [16:0] modulus;
	bit [15:0] exp_c0[$];
	bit [15:0] exp_c1[$];
	bit [15:0] exp_c2[$];
	int        errors;

	function void set_modulus(bit [16:0] value);
		modulus = value;
	endfunction

	// Work out the three shares of a*b for one accepted word.
	function void note_word(bit [15:0] a0, bit [15:0] a1, bit [15:0] a2,
			bit [15:0] b0, bit [15:0] b1, bit [15:0] b2,
			bit [15:0] r01, bit [15:0] r02, bit [15:0] r12);
		longint unsigned q;
		longint unsigned a[3];
		longint unsigned b[3];
		longint unsigned c[3];
		longint unsigned rw[3];
		longint unsigned r;
		longint unsigned t;
		int              k;
		q = modulus;
		if (q == 0) q = 1;
		if (q > 65536) q = 65536;
		a[0] = a0; a[1] = a1; a[2] = a2;
		b[0] = b0; b[1] = b1; b[2] = b2;
		// Random words for pairs (0,1), (0,2), (1,2), indexed by i+j-1.
		rw[0] = r01; rw[1] = r02; rw[2] = r12;
		for (int i = 0; i < 3; i++) c[i] = (a[i] * b[i]) % q;
		for (int i = 0; i < 3; i++) begin
			for (int j = i + 1; j < 3; j++) begin
				k = i + j - 1;
				r = rw[k] % q;
				t = (r + a[i] * b[j] + a[j] * b[i]) % q;
				c[i] = (c[i] + q - r) % q;
				c[j] = (c[j] + t) % q;
			end
		end
		exp_c0.push_back(c[0][15:0]);
		exp_c1.push_back(c[1][15:0]);
		exp_c2.push_back(c[2][15:0]);
	endfunction

	function void check_result(bit [15:0] c0, bit [15:0] c1, bit [15:0] c2);
		bit [15:0] e0;
		bit [15:0] e1;
		bit [15:0] e2;
		if (exp_c0.size() == 0) begin
			$error("result with no word outstanding: %h %h %h", c0, c1, c2);
			errors++;
			return;
		end
		e0 = exp_c0.pop_front();
		e1 = exp_c1.pop_front();
		e2 = exp_c2.pop_front();
		if (c0 !== e0) begin
			$error("c_share0 expected %0d actual %0d", e0, c0);
			errors++;
		end
		if (c1 !== e1) begin
			$error("c_share1 expected %0d actual %0d", e1, c1);
			errors++;
		end
		if (c2 !== e2) begin
			$error("c_share2 expected %0d actual %0d", e2, c2);
			errors++;
		end
	endfunction

	function int pending();
		return exp_c0.size();
	endfunction
endclass

module tb_top;
	import mmm_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               modulus_we;
	logic [MOD_W-1:0]   modulus_wdata;
	logic               start;
	logic               busy;
	logic [SHARE_W-1:0] a_share0, a_share1, a_share2;
	logic [SHARE_W-1:0] b_share0, b_share1, b_share2;
	logic [SHARE_W-1:0] rand_01, rand_02, rand_12;
	logic               done;
	logic [SHARE_W-1:0] c_share0, c_share1, c_share2;

	share_product_board board;
	// When set, the sender never idles between words.
	bit                 no_gaps;

	masked_modular_multiply_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata),
		.start         (start),
		.busy          (busy),
		.a_share0      (a_share0),
		.a_share1      (a_share1),
		.a_share2      (a_share2),
		.b_share0      (b_share0),
		.b_share1      (b_share1),
		.b_share2      (b_share2),
		.rand_01       (rand_01),
		.rand_02       (rand_02),
		.rand_12       (rand_12),
		.done          (done),
		.c_share0      (c_share0),
		.c_share1      (c_share1),
		.c_share2      (c_share2)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous ceiling: the worst case is far below this even with every gap.
	initial begin
		#30ms;
		$display("tb_top: FAIL");
		$finish;
	end

	// Results cannot be held off, so every done strobe is checked at the edge
	// that accepts it.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			board.check_result(c_share0, c_share1, c_share2);
		end
	end

	// Present one word and hold it until the block takes it. The prediction is
	// noted at the accepting edge, so it is in the queue long before done.
	// Start is left high afterwards; the next word, an idle cycle or a drain
	// decides its level.
	task automatic send_word(input logic [SHARE_W-1:0] w[9]);
		if (!no_gaps) begin
			while ($urandom_range(99) < 16) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start    <= 1'b1;
		a_share0 <= w[0];
		a_share1 <= w[1];
		a_share2 <= w[2];
		b_share0 <= w[3];
		b_share1 <= w[4];
		b_share2 <= w[5];
		rand_01  <= w[6];
		rand_02  <= w[7];
		rand_12  <= w[8];
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		board.note_word(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]);
	endtask

	// Let the pipeline empty, then a further margin beyond the latency.
	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Modulus writes only on an idle block; the Barrett constant rebuild then
	// holds busy high, which send_word simply waits out.
	task automatic write_modulus(input logic [MOD_W-1:0] value);
		drain();
		modulus_we    <= 1'b1;
		modulus_wdata <= value;
		@(posedge clk);
		modulus_we <= 1'b0;
		board.set_modulus(value);
		@(posedge clk);
	endtask

	task automatic send_random(input int count, input bit big_shares);
		logic [SHARE_W-1:0] w[9];
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 9; k++) begin
				// Mostly full-range words; now and then small ones so that
				// shares below q are well covered too.
				if (big_shares || $urandom_range(3) != 0) w[k] = SHARE_W'($urandom);
				else w[k] = SHARE_W'($urandom_range(
					board.modulus > 1 ? board.modulus - 1 : 0));
			end
			send_word(w);
		end
	endtask

	logic [SHARE_W-1:0] dw[9];
	logic [MOD_W-1:0]   mods[8];

	initial begin
		board = new();
		board.set_modulus(MOD_RESET);
		no_gaps       = 1'b0;
		arst_n        = 1'b0;
		modulus_we    = 1'b0;
		modulus_wdata = '0;
		start         = 1'b0;
		a_share0 = '0; a_share1 = '0; a_share2 = '0;
		b_share0 = '0; b_share1 = '0; b_share2 = '0;
		rand_01  = '0; rand_02  = '0; rand_12  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset modulus: zeros, all ones, single large
		// words among ones, alternating bit patterns and every word at q - 1.
		for (int k = 0; k < 9; k++) dw[k] = '0;
		send_word(dw);
		for (int k = 0; k < 9; k++) dw[k] = '1;
		send_word(dw);
		for (int k = 0; k < 9; k++) begin
			for (int m = 0; m < 9; m++) dw[m] = (m == k) ? 16'hFFFF : 16'd1;
			send_word(dw);
		end
		for (int k = 0; k < 9; k++) dw[k] = (k[0]) ? 16'hAAAA : 16'h5555;
		send_word(dw);
		for (int k = 0; k < 9; k++) dw[k] = 16'd8191;
		send_word(dw);

		// Modulus one, zero and above 65536 all force trivial or clamped
		// arithmetic; the upper extreme and 65536 itself follow.
		mods = '{17'd1, 17'd0, 17'h1FFFF, 17'd65536, 17'd2, 17'd65521,
			17'd3329, 17'd12289};
		for (int m = 0; m < 4; m++) begin
			write_modulus(mods[m]);
			for (int k = 0; k < 9; k++) dw[k] = '1;
			send_word(dw);
			send_random(3, 1'b1);
		end

		// Random part across several moduli, with one burst with no gaps and
		// one pause until every result is back.
		for (int m = 0; m < 8; m++) begin
			write_modulus(mods[m]);
			if (m == 5) no_gaps = 1'b1;
			send_random(100, m[0]);
			no_gaps = 1'b0;
			if (m == 2) drain();
		end
		write_modulus(MOD_W'($urandom_range(131071)));
		send_random(200, 1'b0);
		write_modulus(MOD_W'($urandom_range(65536, 2)));
		send_random(200, 1'b1);

		drain();
		if (board.errors == 0 && board.pending() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule

FILE: masked_modular_multiply_core.f
rtl/mmm_pkg.sv
rtl/mmm_mu_div.sv
rtl/mmm_barrett.sv
rtl/mmm_combine.sv
rtl/masked_modular_multiply_core.sv
dv/tb_top.sv
